// ===== src/lbf_pkg.sv =====
`default_nettype none
package lbf_pkg;

   // Table geometry
   localparam int NUM_PORTS     = 8;
   localparam int NUM_DBS       = 4;
   localparam int TABLE_ENTRIES = 1024;
   localparam int IDX_W         = $clog2(TABLE_ENTRIES);
   localparam int DB_W          = 2;
   localparam int SLOT_W        = IDX_W + DB_W;
   localparam int MASK_W        = 8;
   localparam int PORT_W        = 3;
   localparam int PRIO_W        = 3;
   localparam int TIME_W        = 32;
   localparam int AGE_W         = 24;
   localparam int CSR_W         = 24;
   localparam int CSR_IDX_W     = 2;

   // Frame field constants
   localparam logic [15:0] VLAN_TPID = 16'h8100;
   localparam logic [31:0] BCAST_MAC = 32'hFFFF_FFFF;
   localparam int          MCAST_BIT = 31;
   localparam logic [MASK_W-1:0] FLOOD_MASK =
      (NUM_PORTS >= MASK_W) ? {MASK_W{1'b1}} : MASK_W'((1 << NUM_PORTS) - 1);
   localparam logic [DB_W-1:0] DB_MAX = DB_W'(NUM_DBS - 1);

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_AGE_TIME  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PRIO_MAP  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DB_MAP    = 2'd2;

   // Source classes
   localparam logic [1:0] SCLASS_UNICAST   = 2'd0;
   localparam logic [1:0] SCLASS_MULTICAST = 2'd1;
   localparam logic [1:0] SCLASS_BROADCAST = 2'd2;

   // Classified beat passed from front to back
   typedef struct packed {
      logic                 is_tick;
      logic                 drop;
      logic [PORT_W-1:0]    port;
      logic [1:0]           sclass;
      logic [PRIO_W-1:0]    prio;
      logic [SLOT_W-1:0]    src_slot;
      logic [SLOT_W-1:0]    dst_slot;
      logic                 dst_bcast;
   } item_type;

   // One MAC table entry
   typedef struct packed {
      logic                 valid;
      logic [MASK_W-1:0]    ports;
      logic [TIME_W-1:0]    birth;
   } entry_type;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_RUN,
      ST_SRC,
      ST_DST
   } state_type;

endpackage
`default_nettype wire

// ===== src/lbf_front.sv =====
`default_nettype none
module lbf_front (
   input  wire logic                       req_kind,
   input  wire logic [lbf_pkg::PORT_W-1:0] req_ingress_port,
   input  wire logic [31:0]                req_dst_mac,
   input  wire logic [31:0]                req_src_mac,
   input  wire logic [15:0]                req_tag_type,
   input  wire logic [lbf_pkg::PRIO_W-1:0] req_vlan_priority,
   input  wire logic [lbf_pkg::CSR_W-1:0]  prio_map,
   input  wire logic [15:0]                db_map,
   output lbf_pkg::item_type               item
);
   import lbf_pkg::*;

   logic [4:0]      prio_idx;
   logic [3:0]      db_idx;
   logic [DB_W-1:0] db_raw;
   logic [DB_W-1:0] db;

   // Per-port lookups into the default maps
   assign prio_idx = 5'(req_ingress_port) * 5'd3;
   assign db_idx   = {req_ingress_port, 1'b0};
   assign db_raw   = db_map[db_idx +: DB_W];
   assign db       = ({1'b0, db_raw} >= (DB_W+1)'(NUM_DBS)) ? DB_MAX : db_raw;

   // Classify the beat
   always_comb begin
      item.is_tick  = req_kind;
      item.drop     = ({1'b0, req_ingress_port} >= (PORT_W+1)'(NUM_PORTS));
      item.port     = req_ingress_port;
      item.prio     = (req_tag_type == VLAN_TPID) ? req_vlan_priority
                                                  : prio_map[prio_idx +: PRIO_W];
      if (req_src_mac == BCAST_MAC) begin
         item.sclass = SCLASS_BROADCAST;
      end else if (req_src_mac[MCAST_BIT]) begin
         item.sclass = SCLASS_MULTICAST;
      end else begin
         item.sclass = SCLASS_UNICAST;
      end
      item.src_slot  = {db, req_src_mac[IDX_W-1:0]};
      item.dst_slot  = {db, req_dst_mac[IDX_W-1:0]};
      item.dst_bcast = (req_dst_mac == BCAST_MAC);
   end

endmodule
`default_nettype wire

// ===== src/lbf_queue.sv =====
`default_nettype none
module lbf_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire lbf_pkg::item_type push_item,
   output logic                   full,
   input  wire logic              pop,
   output logic                   head_valid,
   output lbf_pkg::item_type      head_item
);
   import lbf_pkg::*;

   item_type   slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   assign full       = (count_ff == 2'd2);
   assign head_valid = (count_ff != 2'd0);
   assign head_item  = slot_ff[rd_ptr_ff];

   // Pointer and count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule
`default_nettype wire

// ===== src/lbf_back.sv =====
`default_nettype none
module lbf_back (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic [lbf_pkg::AGE_W-1:0]  age_time,
   input  wire logic                       head_valid,
   input  wire lbf_pkg::item_type          head_item,
   output logic                            pop,
   output logic                            init_done,
   output logic                            rsp_valid,
   input  wire logic                       rsp_ready,
   output logic [lbf_pkg::MASK_W-1:0]      rsp_port_mask,
   output logic [lbf_pkg::PRIO_W-1:0]      rsp_priority_res,
   output logic                            rsp_flooded,
   output logic                            rsp_learned,
   output logic [1:0]                      rsp_source_class
);
   import lbf_pkg::*;

   localparam int DEPTH = NUM_DBS * TABLE_ENTRIES;

   // Table memory
   entry_type mem [DEPTH];
   entry_type rdata_ff;

   state_type state_ff, state_in;
   logic [SLOT_W-1:0] clr_addr_ff, clr_addr_in;
   logic [TIME_W-1:0] time_ff, time_in;
   entry_type         fwd_ff, fwd_in;
   logic              fwd_hit_ff, fwd_hit_in;
   logic              learned_ff, learned_in;

   logic              rsp_valid_ff;
   logic [MASK_W-1:0] mask_ff;
   logic [PRIO_W-1:0] prio_ff;
   logic              flooded_ff;
   logic              learned_out_ff;
   logic [1:0]        sclass_ff;

   logic              we, re, out_load, out_free;
   logic [SLOT_W-1:0] waddr, raddr;
   entry_type         wdata, dent;
   logic [TIME_W-1:0] src_elapsed, dst_elapsed;
   logic              src_live, src_hit, dst_live, dst_expired;
   logic [MASK_W-1:0] port_bit;
   logic [MASK_W-1:0] out_mask;
   logic              out_flooded, out_learned;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign init_done = (state_ff != ST_CLEAR);
   assign port_bit  = MASK_W'(1) << head_item.port;

   // Lazy aging on both lookups
   assign dent        = fwd_hit_ff ? fwd_ff : rdata_ff;
   assign src_elapsed = time_ff - rdata_ff.birth;
   assign dst_elapsed = time_ff - dent.birth;
   assign src_live    = rdata_ff.valid && (src_elapsed <= TIME_W'(age_time));
   assign src_hit     = src_live && (rdata_ff.ports != '0);
   assign dst_live    = dent.valid && (dst_elapsed <= TIME_W'(age_time));
   assign dst_expired = dent.valid && !dst_live;

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (clr_addr_ff == SLOT_W'(DEPTH - 1)) begin
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            if (head_valid && !head_item.is_tick && !head_item.drop) begin
               state_in = ST_SRC;
            end
         end
         ST_SRC: begin
            state_in = ST_DST;
         end
         ST_DST: begin
            if (out_free) begin
               state_in = ST_RUN;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   // Datapath controls
   always_comb begin
      we          = 1'b0;
      re          = 1'b0;
      waddr       = head_item.src_slot;
      raddr       = head_item.src_slot;
      wdata       = '0;
      pop         = 1'b0;
      out_load    = 1'b0;
      out_mask    = '0;
      out_flooded = 1'b0;
      out_learned = 1'b0;
      clr_addr_in = clr_addr_ff;
      time_in     = time_ff;
      fwd_in      = fwd_ff;
      fwd_hit_in  = fwd_hit_ff;
      learned_in  = learned_ff;
      case (state_ff)
         ST_CLEAR: begin
            we          = 1'b1;
            waddr       = clr_addr_ff;
            clr_addr_in = clr_addr_ff + 1'b1;
         end
         ST_RUN: begin
            if (head_valid) begin
               if (head_item.is_tick) begin
                  time_in = time_ff + 1'b1;
                  pop     = 1'b1;
               end else if (head_item.drop) begin
                  if (out_free) begin
                     out_load = 1'b1;
                     pop      = 1'b1;
                  end
               end else begin
                  re = 1'b1;
               end
            end
         end
         ST_SRC: begin
            // Learn or refresh a unicast source, then look up the destination
            wdata.valid = 1'b1;
            wdata.ports = src_hit ? rdata_ff.ports : port_bit;
            wdata.birth = time_ff;
            we          = (head_item.sclass == SCLASS_UNICAST);
            learned_in  = we && !src_hit;
            fwd_in      = wdata;
            fwd_hit_in  = we && (head_item.src_slot == head_item.dst_slot);
            re          = 1'b1;
            raddr       = head_item.dst_slot;
         end
         ST_DST: begin
            out_learned = learned_ff;
            if (head_item.dst_bcast) begin
               out_mask    = FLOOD_MASK;
               out_flooded = 1'b1;
            end else if (dst_live && dent.ports != '0) begin
               out_mask = dent.ports;
            end else begin
               out_mask    = FLOOD_MASK;
               out_flooded = 1'b1;
            end
            if (out_free) begin
               out_load    = 1'b1;
               pop         = 1'b1;
               we          = !head_item.dst_bcast && dst_expired;
               waddr       = head_item.dst_slot;
               wdata       = dent;
               wdata.valid = 1'b0;
            end
         end
         default: begin
            we = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_addr_ff  <= '0;
         time_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         clr_addr_ff <= clr_addr_in;
         time_ff     <= time_in;
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      fwd_ff     <= fwd_in;
      fwd_hit_ff <= fwd_hit_in;
      learned_ff <= learned_in;
      if (out_load) begin
         mask_ff        <= out_mask;
         prio_ff        <= head_item.prio;
         flooded_ff     <= out_flooded;
         learned_out_ff <= out_learned;
         sclass_ff      <= head_item.sclass;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_port_mask    = mask_ff;
   assign rsp_priority_res = prio_ff;
   assign rsp_flooded      = flooded_ff;
   assign rsp_learned      = learned_out_ff;
   assign rsp_source_class = sclass_ff;

endmodule
`default_nettype wire

// ===== src/learning_bridge_forwarder.sv =====
`default_nettype none
// Learning bridge forwarder with lazy MAC aging.
// Input channel (req_*): one beat is either a frame header (req_kind 0) or a
// time tick (req_kind 1). A tick advances the 32-bit clock and yields no beat
// on the result channel; a frame yields exactly one rsp_* beat, in order.
// Configuration (csr_*): age time, default priority map and database map,
// written with csr_wr_en; the user must write them only while the block is
// idle, as the block does not enforce it. Indexes past the list are ignored.
// Timing: a frame takes three steps in the table stage (source read, source
// write plus destination read, result), and the table stage works on one
// frame at a time; a tick is handled in the run state with no table access.
// The table memory has one read and one write port, shared by the source and
// destination lookups. A two-beat queue sits between the classifier and the
// table stage, and the result register lets the next frame proceed while an
// earlier result is still held.
// Reset: after reset is released the table is swept clear, one entry a
// cycle, over all 4096 entries; req_ready stays low until the sweep ends.
// When rsp_ready is low the result is held and the table stage waits;
// the queue then fills and req_ready drops.
module learning_bridge_forwarder (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic                          req_kind,
   input  wire logic [lbf_pkg::PORT_W-1:0]    req_ingress_port,
   input  wire logic [31:0]                   req_dst_mac,
   input  wire logic [31:0]                   req_src_mac,
   input  wire logic [15:0]                   req_tag_type,
   input  wire logic [lbf_pkg::PRIO_W-1:0]    req_vlan_priority,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic [lbf_pkg::MASK_W-1:0]         rsp_port_mask,
   output logic [lbf_pkg::PRIO_W-1:0]         rsp_priority_res,
   output logic                               rsp_flooded,
   output logic                               rsp_learned,
   output logic [1:0]                         rsp_source_class,
   input  wire logic                          csr_wr_en,
   input  wire logic [lbf_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [lbf_pkg::CSR_W-1:0]     csr_wdata
);
   import lbf_pkg::*;

   logic [AGE_W-1:0] age_ff;
   logic [CSR_W-1:0] prio_map_ff;
   logic [15:0]      db_map_ff;

   item_type front_item, head_item;
   logic     q_full, head_valid, pop, init_done, push;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         age_ff      <= AGE_W'(300);
         prio_map_ff <= '0;
         db_map_ff   <= '0;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_AGE_TIME: age_ff      <= csr_wdata[AGE_W-1:0];
            CSR_PRIO_MAP: prio_map_ff <= csr_wdata;
            CSR_DB_MAP:   db_map_ff   <= csr_wdata[15:0];
            default:      age_ff      <= age_ff;
         endcase
      end
   end

   assign req_ready = !q_full && init_done;
   assign push      = req_valid && req_ready;

   lbf_front u_front (
      .req_kind          (req_kind),
      .req_ingress_port  (req_ingress_port),
      .req_dst_mac       (req_dst_mac),
      .req_src_mac       (req_src_mac),
      .req_tag_type      (req_tag_type),
      .req_vlan_priority (req_vlan_priority),
      .prio_map          (prio_map_ff),
      .db_map            (db_map_ff),
      .item              (front_item)
   );

   lbf_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_item  (front_item),
      .full       (q_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_item  (head_item)
   );

   lbf_back u_back (
      .clock            (clock),
      .reset            (reset),
      .age_time         (age_ff),
      .head_valid       (head_valid),
      .head_item        (head_item),
      .pop              (pop),
      .init_done        (init_done),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_port_mask    (rsp_port_mask),
      .rsp_priority_res (rsp_priority_res),
      .rsp_flooded      (rsp_flooded),
      .rsp_learned      (rsp_learned),
      .rsp_source_class (rsp_source_class)
   );

endmodule
`default_nettype wire

// ===== dv/tb.sv =====
`default_nettype none
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import lbf_pkg::*;

   localparam logic KIND_FRAME = 1'b0;
   localparam logic KIND_TICK  = 1'b1;
   localparam int   SETTLE     = 40;
   localparam int   POOL_N     = 32;

   typedef struct {
      logic              kind;
      logic [PORT_W-1:0] port;
      logic [31:0]       dmac;
      logic [31:0]       smac;
      logic [15:0]       tpid;
      logic [PRIO_W-1:0] vprio;
   } hdr_type;

   typedef struct {
      logic [MASK_W-1:0] mask;
      logic [PRIO_W-1:0] prio;
      logic              flooded;
      logic              learned;
      logic [1:0]        sclass;
   } fwd_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic req_kind = 1'b0;
   logic [PORT_W-1:0] req_ingress_port = '0;
   logic [31:0] req_dst_mac = '0;
   logic [31:0] req_src_mac = '0;
   logic [15:0] req_tag_type = '0;
   logic [PRIO_W-1:0] req_vlan_priority = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [MASK_W-1:0] rsp_port_mask;
   logic [PRIO_W-1:0] rsp_priority_res;
   logic rsp_flooded;
   logic rsp_learned;
   logic [1:0] rsp_source_class;
   logic csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_W-1:0] csr_wdata = '0;

   learning_bridge_forwarder u_top (.*);

   always #10 clock = ~clock;

   // shadow of the bridge: table, clock and registers
   logic              mac_live  [NUM_DBS*TABLE_ENTRIES];
   logic [MASK_W-1:0] mac_ports [NUM_DBS*TABLE_ENTRIES];
   logic [31:0]       mac_birth [NUM_DBS*TABLE_ENTRIES];
   logic [31:0]       tick_count = '0;
   logic [23:0]       age_limit = 24'd300;
   logic [23:0]       prio_map = '0;
   logic [15:0]       db_map = '0;

   hdr_type hdr_q[$];
   fwd_type fwd_q[$];
   int      errors = 0;
   bit      quiet = 0;
   logic [31:0] mac_pool[POOL_N];

   initial begin
      for (int i = 0; i < NUM_DBS*TABLE_ENTRIES; i++) begin
         mac_live[i] = 1'b0;
         mac_ports[i] = '0;
         mac_birth[i] = '0;
      end
   end

   // live ports of a slot; an aged entry is dropped on the way
   function automatic logic [MASK_W-1:0] live_ports(int unsigned s);
      if (!mac_live[s]) return '0;
      if (32'(tick_count - mac_birth[s]) > {8'h0, age_limit}) begin
         mac_live[s] = 1'b0;
         return '0;
      end
      return mac_ports[s];
   endfunction

   // forwarding decision for one beat; returns 1 when a result is due
   function automatic bit forward(hdr_type h, output fwd_type r);
      int unsigned db, s;
      r = '{default: '0};
      if (h.kind == KIND_TICK) begin
         tick_count = tick_count + 32'd1;
         return 0;
      end
      r.prio = (h.tpid == VLAN_TPID) ? h.vprio : PRIO_W'(prio_map >> (3 * h.port));
      if (h.smac == BCAST_MAC)     r.sclass = SCLASS_BROADCAST;
      else if (h.smac[MCAST_BIT])  r.sclass = SCLASS_MULTICAST;
      else                         r.sclass = SCLASS_UNICAST;
      if (h.port < NUM_PORTS) begin
         db = (db_map >> (2 * h.port)) & 3;
         if (db >= NUM_DBS) db = NUM_DBS - 1;
         if (r.sclass == SCLASS_UNICAST) begin
            s = db * TABLE_ENTRIES + (h.smac % TABLE_ENTRIES);
            if (live_ports(s) == 0) begin
               mac_live[s] = 1'b1;
               mac_ports[s] = MASK_W'(1 << h.port);
               r.learned = 1'b1;
            end
            mac_birth[s] = tick_count;
         end
         if (h.dmac != BCAST_MAC)
            r.mask = live_ports(db * TABLE_ENTRIES + (h.dmac % TABLE_ENTRIES));
         if (r.mask == 0) begin
            r.mask = FLOOD_MASK;
            r.flooded = 1'b1;
         end
      end
      return 1;
   endfunction

   // request driver
   int req_gap = 0;
   always @(posedge clock) begin
      hdr_type h;
      fwd_type r;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            h = '{req_kind, req_ingress_port, req_dst_mac, req_src_mac,
                  req_tag_type, req_vlan_priority};
            if (forward(h, r)) fwd_q.push_back(r);
         end
         if (req_valid && !req_ready) begin
            // hold the beat
         end else if (req_gap > 0) begin
            req_gap--;
            req_valid <= 1'b0;
         end else if (!quiet && $urandom_range(0, 11) == 0) begin
            req_gap = $urandom_range(0, 16);
            req_valid <= 1'b0;
         end else if (hdr_q.size() > 0) begin
            h = hdr_q.pop_front();
            req_valid <= 1'b1;
            req_kind <= h.kind;
            req_ingress_port <= h.port;
            req_dst_mac <= h.dmac;
            req_src_mac <= h.smac;
            req_tag_type <= h.tpid;
            req_vlan_priority <= h.vprio;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   function automatic void check_field(string name, int unsigned exp, int unsigned act);
      if (exp != act) begin
         $display("%0t: %s expected %0h actual %0h", $time, name, exp, act);
         errors++;
      end
   endfunction

   // response monitor with stall bursts
   int rsp_stall = 0;
   always @(posedge clock) begin
      fwd_type e;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (fwd_q.size() == 0) begin
               $display("%0t: unexpected result beat mask %0h", $time, rsp_port_mask);
               errors++;
            end else begin
               e = fwd_q.pop_front();
               check_field("port_mask", e.mask, rsp_port_mask);
               check_field("priority_res", e.prio, rsp_priority_res);
               check_field("flooded", e.flooded, rsp_flooded);
               check_field("learned", e.learned, rsp_learned);
               check_field("source_class", e.sclass, rsp_source_class);
            end
         end
         if (rsp_stall > 0) begin
            rsp_stall--;
            rsp_ready <= 1'b0;
         end else if (!quiet && $urandom_range(0, 11) == 0) begin
            rsp_stall = $urandom_range(0, 16);
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   function automatic void push_frame(logic [2:0] port, logic [31:0] d, logic [31:0] s,
                                      logic [15:0] tpid, logic [2:0] vp);
      hdr_q.push_back('{KIND_FRAME, port, d, s, tpid, vp});
   endfunction

   function automatic void push_tick();
      hdr_q.push_back('{KIND_TICK, 3'($urandom), $urandom, $urandom, 16'($urandom),
                        3'($urandom)});
   endfunction

   function automatic logic [31:0] pick_mac(int pool_pct);
      int unsigned k = $urandom_range(0, 99);
      if (k < pool_pct)      return mac_pool[$urandom_range(0, POOL_N-1)];
      else if (k < pool_pct + 6)  return BCAST_MAC;
      else if (k < pool_pct + 12) return {1'b1, 31'($urandom)};
      else                   return $urandom;
   endfunction

   // mostly frames over a small address pool so hits and refreshes happen
   function automatic void push_random(int n);
      for (int i = 0; i < POOL_N; i++)
         mac_pool[i] = (i >= 24) ? {1'b0, 21'($urandom), mac_pool[i-24][9:0]}
                                 : {1'b0, 31'($urandom)};
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(0, 99) < 15) push_tick();
         else push_frame(3'($urandom), pick_mac(70), pick_mac(80),
                         $urandom_range(0, 1) ? VLAN_TPID : 16'($urandom), 3'($urandom));
      end
   endfunction

   task automatic wait_idle();
      while (hdr_q.size() > 0 || req_valid || fwd_q.size() > 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_regs(logic [23:0] age, logic [23:0] prio, logic [15:0] dbs);
      @(posedge clock);
      csr_wr_en <= 1'b1; csr_index <= CSR_AGE_TIME; csr_wdata <= age;
      @(posedge clock);
      csr_index <= CSR_PRIO_MAP; csr_wdata <= prio;
      @(posedge clock);
      csr_index <= CSR_DB_MAP; csr_wdata <= {8'h0, dbs};
      @(posedge clock);
      csr_wr_en <= 1'b0;
      age_limit = age;
      prio_map = prio;
      db_map = dbs;
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed: reset settings
      push_tick();
      push_frame(3'd0, BCAST_MAC, 32'h0000_0A01, 16'h0000, 3'd0);
      push_frame(3'd1, 32'h0000_0A01, 32'h0000_0B02, VLAN_TPID, 3'd7);
      push_frame(3'd7, 32'h0000_0B02, BCAST_MAC, 16'hFFFF, 3'd5);
      push_frame(3'd3, 32'h8000_0001, 32'h8000_0001, VLAN_TPID, 3'd0);
      push_frame(3'd2, 32'h0000_0C03, 32'h0000_0C03, 16'h8101, 3'd3);
      push_frame(3'd4, 32'h7FFF_FFFF, 32'h0000_0000, 16'h0000, 3'd2);
      push_frame(3'd5, 32'h0000_0000, 32'h7FFF_FFFF, VLAN_TPID, 3'd1);
      push_frame(3'd6, 32'h1234_4A01, 32'h0000_0A01, 16'h8100, 3'd4);
      wait_idle();

      // directed: aging with a short age time
      write_regs(24'd2, 24'hFAC688, 16'hE4E4);
      push_frame(3'd0, BCAST_MAC, 32'h0000_1111, 16'h0000, 3'd0);
      push_tick(); push_tick();
      push_frame(3'd1, 32'h0000_1111, 32'h0000_2222, 16'h0000, 3'd0);
      push_tick(); push_tick(); push_tick();
      push_frame(3'd4, 32'h0000_1111, 32'h0000_2222, 16'h0000, 3'd0);
      push_frame(3'd5, 32'h0000_2222, 32'h0000_3333, VLAN_TPID, 3'd6);
      wait_idle();

      // random phases across register settings
      write_regs(24'hFFFFFF, 24'hFFFFFF, 16'hFFFF);
      push_random(350);
      wait_idle();
      write_regs(24'd0, 24'h000000, 16'h0000);
      push_random(350);
      wait_idle();
      write_regs(24'($urandom_range(1, 12)), 24'($urandom), 16'($urandom));
      push_random(450);
      wait_idle();
      quiet = 1;
      write_regs(24'($urandom_range(3, 40)), 24'($urandom), 16'($urandom));
      push_random(420);
      wait_idle();

      if (errors == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin
      #20_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end
endmodule
`default_nettype wire

// ===== filelist.f =====
src/lbf_pkg.sv
src/lbf_front.sv
src/lbf_queue.sv
src/lbf_back.sv
src/learning_bridge_forwarder.sv
dv/tb.sv
